// ===== rtl/core/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared widths, constants, types and the arctangent table function.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int CORDIC_STAGES_MAX = 32;

	localparam int LAT_W  = 24;
	localparam int LON_W  = 25;
	localparam int DIST_W = 23;

	// CORDIC datapath: 34-bit signed for x, y, z.
	localparam int CW = 34;

	localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;
	localparam logic signed [CW-1:0] GAIN_INV = 34'sh026DD3B6A;
	localparam logic signed [CW-1:0] HALF_TURN = 34'sd2147483648;
	localparam logic [31:0] KM_SCALE = 32'd2623417457;
	localparam logic [DIST_W-1:0] DIST_MAX = 23'd5124000;

	typedef logic signed [CW-1:0] cval_t;

	typedef struct packed {
		cval_t x;
		cval_t y;
		cval_t z;
	} vec_t;

	function automatic cval_t atan_bam(input int i);
		logic [31:0] t;
		unique case (i)
			0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
			2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
			10: t = 32'h000A2F98;  11: t = 32'h000517CC;
			12: t = 32'h00028BE6;  13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
			16: t = 32'h000028BE;  17: t = 32'h0000145F;
			18: t = 32'h00000A30;  19: t = 32'h00000518;
			20: t = 32'h0000028C;  21: t = 32'h00000146;
			22: t = 32'h000000A3;  23: t = 32'h00000051;
			24: t = 32'h00000029;  25: t = 32'h00000014;
			26: t = 32'h0000000A;  27: t = 32'h00000005;
			28: t = 32'h00000003;  29: t = 32'h00000001;
			30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return cval_t'({2'b00, t});
	endfunction

endpackage

// ===== rtl/core/gcd_if.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance channel interfaces
// Valid/ready channels for coordinate items and distance items.
// ----------------------------------------------------------------------------
interface gcd_in_if;
	logic valid;
	logic ready;
	logic signed [gcd_pkg::LAT_W-1:0] first_latitude;
	logic signed [gcd_pkg::LON_W-1:0] first_longitude;
	logic signed [gcd_pkg::LAT_W-1:0] second_latitude;
	logic signed [gcd_pkg::LON_W-1:0] second_longitude;
	modport source (output valid, first_latitude, first_longitude, second_latitude,
		second_longitude, input ready);
	modport sink (input valid, first_latitude, first_longitude, second_latitude,
		second_longitude, output ready);
endinterface

interface gcd_out_if;
	logic valid;
	logic ready;
	logic [gcd_pkg::DIST_W-1:0] distance_km;
	modport source (output valid, distance_km, input ready);
	modport sink (input valid, distance_km, output ready);
endinterface

// ===== rtl/core/gcd_rot_stage.sv =====
// ----------------------------------------------------------------------------
// CORDIC stage
// One registered rotation or vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module gcd_rot_stage #(
	parameter int IDX = 0,
	parameter bit VECT = 1'b0
) (
	input  logic            clk,
	input  logic            en,
	input  gcd_pkg::vec_t   d,
	output gcd_pkg::vec_t   q
);
	gcd_pkg::cval_t dx, dy, t;
	logic           cw;

	always_comb begin
		dx = d.y >>> IDX;
		dy = d.x >>> IDX;
		t  = gcd_pkg::atan_bam(IDX);
		// vectoring turns clockwise while y > 0; rotation goes on z sign
		cw = VECT ? (d.y > 0) : (d.z < 0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (VECT) begin
				q.x <= cw ? d.x + dx : d.x - dx;
				q.y <= cw ? d.y - dy : d.y + dy;
				q.z <= cw ? d.z + t : d.z - t;
			end else begin
				q.x <= cw ? d.x + dx : d.x - dx;
				q.y <= cw ? d.y - dy : d.y + dy;
				q.z <= cw ? d.z + t : d.z - t;
			end
		end
	end
endmodule

// ===== rtl/core/great_circle_distance_core.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance core
// Haversine distance between two points, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: coordinate pairs arrive on the sink channel "in" as signed degrees
// times 65536; distances leave on the source channel "out" in kilometres
// times 256. Every item gives exactly one result.
// The datapath is one long pipeline: angle conversion (2 stages: an exact
// reciprocal quotient by 90, then the remainder table and the fold into
// +-90 degrees), sine and cosine CORDIC (CORDIC_STAGES stages), three
// product stages, two integer square roots (one stage per result bit,
// 31 stages), the arctangent CORDIC (CORDIC_STAGES stages) and two scaling
// stages. The default CORDIC_STAGES is 24.
// Throughput is one item per cycle while "out" is not stalled, set by the per-stage registers.
// The whole pipeline advances together: when "out" is stalled with a result
// waiting, the pipeline holds, and "in" is ready whenever the last stage is
// empty or being taken, so nothing is lost or repeated.
// Reset clears only the valid bits; data registers carry no reset.
// ----------------------------------------------------------------------------
module great_circle_distance_core #(
	parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	gcd_in_if.sink    in,
	gcd_out_if.source out
);
	localparam int NS = (CORDIC_STAGES > gcd_pkg::CORDIC_STAGES_MAX) ?
		gcd_pkg::CORDIC_STAGES_MAX : CORDIC_STAGES;
	localparam int SQ = 31;          // square-root bit steps
	localparam int LAT = 2 * NS + SQ + 7;

	typedef gcd_pkg::cval_t cval_t;
	typedef gcd_pkg::vec_t vec_t;

	// The whole pipe moves when its last stage is empty or taken.
	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !vld_q[LAT-1] || out.ready;
	assign in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in.valid};
		end
	end

	// A binary angle is round(v * 2^k / 360). Writing v = 90*q + r turns
	// this into q shifted left plus a small table entry indexed by r, so
	// only a quotient by 90 of a 27-bit value is needed. The offset makes
	// the value nonnegative; it vanishes modulo a full turn after the shift.
	localparam logic [26:0] DIV_OFS  = 27'd47185920;   // 90 * 2^19
	localparam logic [27:0] RECIP_90 = 28'd190887436;  // ceil(2^34 / 90)

	logic signed [25:0] deg_c [4];
	logic [26:0] u_c [4];
	logic [54:0] pq_c [4];
	logic [26:0] u_s1 [4];
	logic [20:0] qd_s1 [4];
	logic [6:0]  rem_c [4];
	logic [31:0] bam_c [4];
	cval_t ang_c [4];
	vec_t  rot_s2 [4];
	logic  neg_s2 [4];

	// Remainder tables for the half-angle and full-angle conversions.
	logic [12:0] frac_half [90];
	logic [13:0] frac_full [90];
	for (genvar r = 0; r < 90; r++) begin : g_frac
		assign frac_half[r] = 13'((r * 8192 + 45) / 90);
		assign frac_full[r] = 14'((r * 16384 + 45) / 90);
	end

	always_comb begin
		deg_c[0] = 26'(in.second_latitude) - 26'(in.first_latitude);
		deg_c[1] = 26'(in.second_longitude) - 26'(in.first_longitude);
		deg_c[2] = 26'(in.first_latitude);
		deg_c[3] = 26'(in.second_latitude);
	end

	for (genvar k = 0; k < 4; k++) begin : g_ang
		// Stage 1: quotient by 90 from a reciprocal product, exact for
		// every 27-bit value.
		assign u_c[k]  = 27'(deg_c[k]) + DIV_OFS;
		assign pq_c[k] = 55'(u_c[k]) * 55'(RECIP_90);

		always_ff @(posedge clk) begin
			if (en) begin
				u_s1[k]  <= u_c[k];
				qd_s1[k] <= pq_c[k][54:34];
			end
		end

		// Stage 2: remainder, table lookup, wrap to a signed 32-bit angle
		// and fold into +-90 degrees.
		assign rem_c[k] = 7'(u_s1[k] - 27'(qd_s1[k]) * 27'd90);
		if (k < 2) begin : g_half
			assign bam_c[k] = {qd_s1[k][18:0], 13'b0} + 32'(frac_half[rem_c[k]]);
		end else begin : g_full
			assign bam_c[k] = {qd_s1[k][17:0], 14'b0} + 32'(frac_full[rem_c[k]]);
		end
		assign ang_c[k] = cval_t'(signed'(bam_c[k]));

		always_ff @(posedge clk) begin
			if (en) begin
				rot_s2[k].x <= gcd_pkg::GAIN_INV;
				rot_s2[k].y <= '0;
				if (ang_c[k] > gcd_pkg::ONE_Q30) begin
					rot_s2[k].z <= ang_c[k] - gcd_pkg::HALF_TURN;
					neg_s2[k]   <= 1'b1;
				end else if (ang_c[k] < -gcd_pkg::ONE_Q30) begin
					rot_s2[k].z <= ang_c[k] + gcd_pkg::HALF_TURN;
					neg_s2[k]   <= 1'b1;
				end else begin
					rot_s2[k].z <= ang_c[k];
					neg_s2[k]   <= 1'b0;
				end
			end
		end

		vec_t rc [NS+1];
		logic ng [NS+1];
		assign rc[0] = rot_s2[k];
		assign ng[0] = neg_s2[k];
		for (genvar i = 0; i < NS; i++) begin : g_st
			gcd_rot_stage #(.IDX(i), .VECT(1'b0)) u_st (
				.clk(clk), .en(en), .d(rc[i]), .q(rc[i+1]));
			always_ff @(posedge clk) begin
				if (en) ng[i+1] <= ng[i];
			end
		end
	end

	// Sine and cosine results after the rotation pipeline.
	cval_t s1, s2, cl1, cl2;
	assign s1  = g_ang[0].ng[NS] ? -g_ang[0].rc[NS].y : g_ang[0].rc[NS].y;
	assign s2  = g_ang[1].ng[NS] ? -g_ang[1].rc[NS].y : g_ang[1].rc[NS].y;
	assign cl1 = g_ang[2].ng[NS] ? -g_ang[2].rc[NS].x : g_ang[2].rc[NS].x;
	assign cl2 = g_ang[3].ng[NS] ? -g_ang[3].rc[NS].x : g_ang[3].rc[NS].x;

	// Products: three stages.
	logic signed [67:0] p_cc, p_s2, p_s1;
	cval_t cc_p1, s2sq_p1, s1sq_p1;
	cval_t s1sq_p2, term_p2;
	logic [30:0] a_p3;

	assign p_cc = 68'(cl1) * 68'(cl2);
	assign p_s2 = 68'(s2) * 68'(s2);
	assign p_s1 = 68'(s1) * 68'(s1);

	logic signed [67:0] p_t;
	assign p_t = 68'(cc_p1) * 68'(s2sq_p1);
	cval_t a_sum;
	assign a_sum = s1sq_p2 + term_p2;

	always_ff @(posedge clk) begin
		if (en) begin
			cc_p1   <= cval_t'(p_cc >>> 30);
			s2sq_p1 <= cval_t'(p_s2 >>> 30);
			s1sq_p1 <= cval_t'(p_s1 >>> 30);
			s1sq_p2 <= s1sq_p1;
			term_p2 <= cval_t'(p_t >>> 30);
			if (a_sum < 0) a_p3 <= '0;
			else if (a_sum > gcd_pkg::ONE_Q30) a_p3 <= 31'h40000000;
			else a_p3 <= a_sum[30:0];
		end
	end

	// Integer square roots of a*2^30 and (2^30-a)*2^30, one result bit per
	// stage (restoring method on 61-bit radicands).
	logic [61:0] rn [2][SQ+1];
	logic [61:0] rr [2][SQ+1];
	assign rn[0][0] = {a_p3, 31'b0} >> 1;
	assign rn[1][0] = {(31'h40000000 - a_p3), 31'b0} >> 1;
	assign rr[0][0] = '0;
	assign rr[1][0] = '0;

	for (genvar k = 0; k < 2; k++) begin : g_sq
		for (genvar j = 0; j < SQ; j++) begin : g_b
			localparam logic [61:0] BIT = 62'd1 << (2 * (SQ - 1 - j));
			logic [61:0] tr;
			assign tr = rr[k][j] + BIT;
			always_ff @(posedge clk) begin
				if (en) begin
					if (rn[k][j] >= tr) begin
						rn[k][j+1] <= rn[k][j] - tr;
						rr[k][j+1] <= (rr[k][j] >> 1) + BIT;
					end else begin
						rn[k][j+1] <= rn[k][j];
						rr[k][j+1] <= rr[k][j] >> 1;
					end
				end
			end
		end
	end

	// Vectoring CORDIC: angle of (sqrt(1-a), sqrt(a)).
	vec_t vc [NS+1];
	assign vc[0].x = cval_t'(rr[1][SQ]);
	assign vc[0].y = cval_t'(rr[0][SQ]);
	assign vc[0].z = '0;
	for (genvar i = 0; i < NS; i++) begin : g_vc
		gcd_rot_stage #(.IDX(i), .VECT(1'b1)) u_st (
			.clk(clk), .en(en), .d(vc[i]), .q(vc[i+1]));
	end

	// Clamp, double and scale to kilometres.
	logic [30:0] z_f1;
	logic [63:0] d_f2;
	logic [63:0] d_c;
	assign d_c = ((64'(z_f1) << 1) * 64'(gcd_pkg::KM_SCALE) + (64'd1 << 39)) >> 40;

	always_ff @(posedge clk) begin
		if (en) begin
			if (vc[NS].z < 0) z_f1 <= '0;
			else if (vc[NS].z > gcd_pkg::ONE_Q30) z_f1 <= 31'h40000000;
			else z_f1 <= vc[NS].z[30:0];
			d_f2 <= d_c;
		end
	end

	assign out.valid = vld_q[LAT-1];
	assign out.distance_km = (d_f2 > 64'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX :
		d_f2[gcd_pkg::DIST_W-1:0];

	// A held result must stay put while the receiver stalls.
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.distance_km))
		else $error("result changed while stalled");
	// Input is refused only when a result waits.
	ap_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!in.ready |-> out.valid)
		else $error("input stalled without a waiting result");
	// Result never exceeds the clamp.
	ap_max: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.distance_km <= gcd_pkg::DIST_MAX)
		else $error("distance above clamp");
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Great-circle distance core testbench
// Drives coordinate pairs with bursty traffic and a stalling receiver, and
// checks every distance against a bit-true haversine predictor kept here.
// ----------------------------------------------------------------------------

class distance_scoreboard;
	logic [gcd_pkg::DIST_W-1:0] pending[$];
	int errors = 0;

	// Binary angle of a degree value: round(v * mul / 360) with ties upward,
	// wrapped to signed 32 bits.
	static function longint deg_to_angle(longint v, longint mul);
		longint num, q;
		num = v * mul * 2 + 360;
		q = (num + 720 * (64'sd1 <<< 42)) / 720 - (64'sd1 <<< 42);
		return longint'(int'(q[31:0]));
	endfunction

	static function longint atan_step(int i);
		logic [31:0] t[32] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
			32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
			32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
			32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
		return longint'(t[i]);
	endfunction

	// Rotation CORDIC; angles past a right angle are folded by a half turn.
	static function void rotate(longint ang, output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit flip;
		x = 64'h26DD3B6A;
		y = 0;
		z = ang;
		flip = 0;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31;
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31;
			flip = 1;
		end
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	static function longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	static function logic [gcd_pkg::DIST_W-1:0] haversine(longint la1, longint lo1,
			longint la2, longint lo2);
		longint s1, c1, s2, c2, sa, ca, sb, cb, cc, a, y, x, z, dx, dy;
		longint unsigned d;
		rotate(deg_to_angle(la2 - la1, 32768), s1, c1);
		rotate(deg_to_angle(lo2 - lo1, 32768), s2, c2);
		rotate(deg_to_angle(la1, 65536), sa, ca);
		rotate(deg_to_angle(la2, 65536), sb, cb);
		cc = (ca * cb) >>> 30;
		a = ((s1 * s1) >>> 30) + ((cc * ((s2 * s2) >>> 30)) >>> 30);
		if (a < 0) a = 0;
		if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
		y = root_floor(a << 30);
		x = root_floor(((64'sd1 <<< 30) - a) << 30);
		z = 0;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		if (z < 0) z = 0;
		if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
		d = (longint'(z) * 2 * 64'd2623417457 + (64'd1 << 39)) >> 40;
		if (d > 5124000) d = 5124000;
		return d[gcd_pkg::DIST_W-1:0];
	endfunction

	function void note_pair(longint la1, longint lo1, longint la2, longint lo2);
		pending.push_back(haversine(la1, lo1, la2, lo2));
	endfunction

	function void check_distance(logic [gcd_pkg::DIST_W-1:0] got);
		logic [gcd_pkg::DIST_W-1:0] want;
		if (pending.size() == 0) begin
			$error("distance_km: unexpected result %0d", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			$error("distance_km: expected %0d, actual %0d", want, got);
			errors++;
		end
	endfunction
endclass

module tb_top;
	// Pipeline latency with the default stage count.
	localparam int LATENCY = 2 * gcd_pkg::CORDIC_STAGES_DEF + 38;
	localparam int N_RANDOM = 1230;
	localparam longint LAT_LIM = 5898240;
	localparam longint LON_LIM = 11796480;

	logic clk;
	logic arst_n;
	gcd_in_if  pair_ch();
	gcd_out_if dist_ch();

	great_circle_distance_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(pair_ch.sink),
		.out(dist_ch.source)
	);

	distance_scoreboard board = new();
	bit hold_receiver = 0;
	bit drain_pause = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// Send one pair: hold it until it is taken, then either drop valid and let
	// the channel go idle or keep it high for a back-to-back item. The predictor
	// sees the fields exactly as they are driven, sign extended.
	task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2,
			bit keep_valid);
		pair_ch.valid <= 1;
		pair_ch.first_latitude <= la1[gcd_pkg::LAT_W-1:0];
		pair_ch.first_longitude <= lo1[gcd_pkg::LON_W-1:0];
		pair_ch.second_latitude <= la2[gcd_pkg::LAT_W-1:0];
		pair_ch.second_longitude <= lo2[gcd_pkg::LON_W-1:0];
		do @(posedge clk); while (!pair_ch.ready);
		board.note_pair(longint'(signed'(la1[gcd_pkg::LAT_W-1:0])),
			longint'(signed'(lo1[gcd_pkg::LON_W-1:0])),
			longint'(signed'(la2[gcd_pkg::LAT_W-1:0])),
			longint'(signed'(lo2[gcd_pkg::LON_W-1:0])));
		if (!keep_valid) begin
			pair_ch.valid <= 0;
			@(posedge clk);
		end
	endtask

	function automatic longint rand_span(longint lim);
		return longint'($urandom_range(2 * lim)) - lim;
	endfunction

	// Random raw bit pattern of the given width, sign extended.
	function automatic longint rand_raw(int w);
		logic [31:0] r;
		r = $urandom;
		return longint'(signed'(r << (32 - w))) >>> (32 - w);
	endfunction

	// Receiver: a stall pattern of its own, plus one long hold-off on request.
	initial begin
		dist_ch.ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (dist_ch.valid && dist_ch.ready)
				board.check_distance(dist_ch.distance_km);
			if (hold_receiver)
				dist_ch.ready <= 0;
			else if ($urandom_range(9) < 3 && ($urandom & 32'h100))
				dist_ch.ready <= 0;
			else
				dist_ch.ready <= 1;
		end
	end

	initial begin
		int gap, burst, hold;
		longint la1, lo1, la2, lo2;
		pair_ch.valid <= 0;
		pair_ch.first_latitude <= '0;
		pair_ch.first_longitude <= '0;
		pair_ch.second_latitude <= '0;
		pair_ch.second_longitude <= '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, equal points, antipodes, poles, dateline.
		send_pair(0, 0, 0, 0, 0);
		send_pair(LAT_LIM, LON_LIM, LAT_LIM, LON_LIM, 1);
		send_pair(0, 0, 0, LON_LIM, 1);
		send_pair(LAT_LIM, 0, -LAT_LIM, 0, 1);
		send_pair(-LAT_LIM, -LON_LIM, LAT_LIM, LON_LIM, 1);
		send_pair(0, -LON_LIM, 0, LON_LIM, 0);
		send_pair(2949120, 0, -2949120, LON_LIM, 1);
		send_pair(-LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM, 1);
		send_pair(1, 1, 0, 0, 1);
		send_pair(3342336, 6553600, 3276800, 6619136, 0);
		// Edge bit patterns and out-of-range values, including all-ones and sign-bit-only values.
		send_pair(-1, -1, 0, 0, 1);
		send_pair(-(64'sd1 <<< 23), -(64'sd1 <<< 24), (64'sd1 <<< 23) - 1,
			(64'sd1 <<< 24) - 1, 1);
		send_pair((64'sd1 <<< 23) - 1, (64'sd1 <<< 24) - 1, -(64'sd1 <<< 23),
			-(64'sd1 <<< 24), 0);
		send_pair(8000000, 16000000, -8000000, -16000000, 1);
		send_pair(0, 0, 0, 11796480 / 2, 0);

		// Random traffic in bursts; a long receiver hold-off in the middle and
		// one drain pause.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 400) begin
				fork
					begin
						hold_receiver = 1;
						hold = 0;
						while (hold < 3 * LATENCY) begin
							@(posedge clk);
							hold++;
						end
						hold_receiver = 0;
					end
				join_none
			end
			if (n == 800) begin
				pair_ch.valid <= 0;
				drain_pause = 1;
				while (board.pending.size() != 0) @(posedge clk);
				drain_pause = 0;
			end
			if (burst == 0) begin
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
				repeat (gap) @(posedge clk);
				burst = $urandom_range(1, 40);
			end
			burst--;
			case ($urandom_range(9))
				0: begin
					// Any bit pattern at all.
					la1 = rand_raw(gcd_pkg::LAT_W); lo1 = rand_raw(gcd_pkg::LON_W);
					la2 = rand_raw(gcd_pkg::LAT_W); lo2 = rand_raw(gcd_pkg::LON_W);
				end
				1: begin
					// Nearby points.
					la1 = rand_span(LAT_LIM); lo1 = rand_span(LON_LIM);
					la2 = la1 + $urandom_range(2000) - 1000;
					lo2 = lo1 + $urandom_range(2000) - 1000;
				end
				2: begin
					// Near antipodes.
					la1 = rand_span(LAT_LIM); lo1 = rand_span(LON_LIM / 2);
					la2 = -la1 + $urandom_range(64) - 32;
					lo2 = lo1 + LON_LIM - $urandom_range(64);
				end
				default: begin
					la1 = rand_span(LAT_LIM); lo1 = rand_span(LON_LIM);
					la2 = rand_span(LAT_LIM); lo2 = rand_span(LON_LIM);
				end
			endcase
			send_pair(la1, lo1, la2, lo2, burst != 0);
		end
		pair_ch.valid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/gcd_pkg.sv
rtl/core/gcd_if.sv
rtl/core/gcd_rot_stage.sv
rtl/core/great_circle_distance_core.sv
dv/tb_top.sv
